// ===== sv/mlbb_pkg.sv =====
// Shared widths, command codes and register map of the LED blink and burst controller.
package mlbb_pkg;

   localparam int CMD_W      = 3;
   localparam int INDEX_W    = 4;
   localparam int MILLIS_W   = 13;
   localparam int LEVELS_W   = 9;
   localparam int TICK_W     = 8;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   typedef logic [CMD_W-1:0]      cmd_type;
   typedef logic [MILLIS_W-1:0]   millis_type;
   typedef logic [LEVELS_W-1:0]   levels_type;
   typedef logic [TICK_W-1:0]     tick_type;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam cmd_type CMD_TICK   = 3'd0;
   localparam cmd_type CMD_OFF    = 3'd1;
   localparam cmd_type CMD_ON     = 3'd2;
   localparam cmd_type CMD_BLINK  = 3'd3;
   localparam cmd_type CMD_TOGGLE = 3'd4;
   localparam cmd_type CMD_BURST  = 3'd5;

   // Pending slot empty and mode idle share the tick code.
   localparam cmd_type CMD_NONE   = CMD_TICK;

   localparam tick_type     TICK_RESET    = 8'd8;
   localparam csr_addr_type CSR_TICK_ADDR = 2'd0;

endpackage

// ===== sv/multi_led_blink_burst_controller.sv =====
// Top level: LED bank blink and burst controller with a per-LED update sequencer.
// Results: a command transfer gives no result; a tick transfer gives its level vector once
//   the sequencer has updated every LED, one LED per cycle, and loaded the result register.
// Flow: a new tick waits for the walk over every LED by the single per-LED update unit;
//   commands are taken one per cycle while idle and while no result waits on a stall.
// Reset: synchronous, active high; clears every LED, every pending slot, tick length to 8.
module multi_led_blink_burst_controller #(
   parameter int NUM_LEDS = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   // Input channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mlbb_pkg::cmd_type      req_command,
   input  logic [3:0]             req_led_index,
   input  mlbb_pkg::millis_type   req_millis,
   // Result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mlbb_pkg::levels_type   rsp_led_levels,
   // Configuration port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  mlbb_pkg::csr_addr_type csr_paddr,
   input  mlbb_pkg::csr_data_type csr_pwdata,
   output mlbb_pkg::csr_data_type csr_prdata,
   output logic                   csr_pready
);
   import mlbb_pkg::*;

   localparam int LED_IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam logic [LED_IDX_W-1:0] LAST_LED = LED_IDX_W'(NUM_LEDS - 1);

   // Sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // Per-LED state, one entry per LED
   cmd_type    pend_cmd_ff    [NUM_LEDS];
   millis_type pend_millis_ff [NUM_LEDS];
   cmd_type    mode_ff        [NUM_LEDS];
   logic       lit_ff         [NUM_LEDS];
   millis_type period_ff      [NUM_LEDS];
   millis_type remain_ff      [NUM_LEDS];

   logic [1:0]           state_ff, state_in;
   logic [LED_IDX_W-1:0] led_ff, led_in;
   tick_type             tick_len_ff;
   logic                 rsp_valid_ff;
   levels_type           rsp_levels_ff;

   // ---------------------------------------------------------------
   // Input handshake: stall while the sequencer walks the LEDs, and
   // while an earlier result still waits on a stalled result channel.
   // ---------------------------------------------------------------
   logic                 req_take;
   logic                 tick_take;
   logic                 cmd_take;
   logic [LED_IDX_W-1:0] cmd_slot;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;
   assign tick_take = req_take && (req_command == CMD_TICK);
   // Drop unknown command codes and indexes past the bank.
   assign cmd_take  = req_take && (req_command != CMD_TICK) && (req_command <= CMD_BURST)
                      && (32'(req_led_index) < NUM_LEDS);
   assign cmd_slot  = LED_IDX_W'(req_led_index);

   // ---------------------------------------------------------------
   // Shared per-LED update unit: apply the pending command of the LED
   // under the sequencer, then advance its countdown by one tick.
   // ---------------------------------------------------------------
   cmd_type    cur_cmd, cur_mode, mode_mid, mode_in;
   millis_type cur_millis, cur_remain, cur_period;
   millis_type period_mid, remain_mid, remain_in;
   logic       cur_lit, lit_mid, lit_in;
   logic       remain_covers;
   millis_type tick_ext;

   assign cur_cmd    = pend_cmd_ff[led_ff];
   assign cur_millis = pend_millis_ff[led_ff];
   assign cur_mode   = mode_ff[led_ff];
   assign cur_lit    = lit_ff[led_ff];
   assign cur_period = period_ff[led_ff];
   assign cur_remain = remain_ff[led_ff];
   assign tick_ext   = MILLIS_W'(tick_len_ff);

   always_comb begin
      mode_mid   = cur_mode;
      lit_mid    = cur_lit;
      period_mid = cur_period;
      remain_mid = cur_remain;
      if (cur_cmd != CMD_NONE) begin
         if (cur_cmd == cur_mode) begin
            // Repeat of the running mode: blink retunes, burst restarts.
            if (cur_cmd == CMD_BLINK) begin
               period_mid = cur_millis;
               if (cur_millis < cur_remain) begin
                  remain_mid = cur_millis;
               end
            end else if (cur_cmd == CMD_BURST) begin
               remain_mid = cur_millis;
            end
         end else begin
            mode_mid = cur_cmd;
            case (cur_cmd)
               CMD_OFF: begin
                  lit_mid = 1'b0;
               end
               CMD_ON: begin
                  lit_mid = 1'b1;
               end
               CMD_BLINK: begin
                  period_mid = cur_millis;
                  remain_mid = cur_millis;
               end
               CMD_TOGGLE: begin
                  // Settle the mode at on or off so a later toggle acts again.
                  lit_mid  = !cur_lit;
                  mode_mid = cur_lit ? CMD_OFF : CMD_ON;
               end
               CMD_BURST: begin
                  remain_mid = cur_millis;
               end
               default: begin
                  mode_mid = cur_cmd;
               end
            endcase
         end
      end
   end

   assign remain_covers = (remain_mid >= tick_ext);

   always_comb begin
      mode_in   = mode_mid;
      lit_in    = lit_mid;
      remain_in = remain_mid;
      if (mode_mid == CMD_BLINK) begin
         if (remain_covers) begin
            remain_in = remain_mid - tick_ext;
         end else begin
            // Half-period expired: reload and flip.
            remain_in = period_mid;
            lit_in    = !lit_mid;
         end
      end else if (mode_mid == CMD_BURST) begin
         if (remain_covers) begin
            remain_in = remain_mid - tick_ext;
            lit_in    = 1'b1;
         end else begin
            // Burst over: go dark and stay off.
            lit_in  = 1'b0;
            mode_in = CMD_OFF;
         end
      end
   end

   // ---------------------------------------------------------------
   // Sequencer: walk LED 0 up to the last one, then load the result.
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      led_in   = led_ff;
      case (state_ff)
         ST_IDLE: begin
            led_in = '0;
            if (tick_take) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (led_ff == LAST_LED) begin
               state_in = ST_DONE;
            end else begin
               led_in = led_ff + 1'b1;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
            led_in   = '0;
         end
         default: begin
            state_in = ST_IDLE;
            led_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         led_ff   <= '0;
      end else begin
         state_ff <= state_in;
         led_ff   <= led_in;
      end
   end

   // Per-LED storage: command transfers fill the pending slot, the
   // sequencer takes and clears it as it updates each LED.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEDS; i++) begin
            pend_cmd_ff[i]    <= CMD_NONE;
            pend_millis_ff[i] <= '0;
            mode_ff[i]        <= CMD_NONE;
            lit_ff[i]         <= 1'b0;
            period_ff[i]      <= '0;
            remain_ff[i]      <= '0;
         end
      end else if (state_ff == ST_RUN) begin
         pend_cmd_ff[led_ff] <= CMD_NONE;
         mode_ff[led_ff]     <= mode_in;
         lit_ff[led_ff]      <= lit_in;
         period_ff[led_ff]   <= period_mid;
         remain_ff[led_ff]   <= remain_in;
      end else if (cmd_take) begin
         // Latest write wins.
         pend_cmd_ff[cmd_slot]    <= req_command;
         pend_millis_ff[cmd_slot] <= req_millis;
      end
   end

   // ---------------------------------------------------------------
   // Result register: holds the level vector until the transfer.
   // ---------------------------------------------------------------
   levels_type levels_now;

   always_comb begin
      levels_now = '0;
      for (int b = 0; b < LEVELS_W; b++) begin
         if (b < NUM_LEDS) begin
            levels_now[b] = lit_ff[b];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE) begin
         rsp_levels_ff <= levels_now;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_levels = rsp_levels_ff;

   // ---------------------------------------------------------------
   // Configuration port: one register, tick length in milliseconds.
   // ---------------------------------------------------------------
   logic csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_len_ff <= TICK_RESET;
      end else if (csr_write && (csr_paddr == CSR_TICK_ADDR)) begin
         tick_len_ff <= csr_pwdata[TICK_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr == CSR_TICK_ADDR) ? CSR_DATA_W'(tick_len_ff) : '0;

`ifndef SYNTHESIS
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("input taken while the sequencer is busy");

   a_tick_starts_run: assert property (@(posedge clock) disable iff (reset)
      tick_take |=> (state_ff == ST_RUN) && (led_ff == '0))
      else $error("tick transfer did not start the LED walk at LED 0");

   a_led_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (32'(led_ff) < NUM_LEDS))
      else $error("sequencer points past the LED bank");

   a_done_gives_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished walk did not present a result");
`endif

endmodule

// ===== bench/led_level_checker.sv =====
// Transfer monitor and level predictor for the LED blink and burst controller.
`timescale 1ns / 100ps

module led_level_checker #(
   parameter int NUM_LEDS = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  mlbb_pkg::cmd_type      req_command,
   input  logic [3:0]             req_led_index,
   input  mlbb_pkg::millis_type   req_millis,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  mlbb_pkg::levels_type   rsp_led_levels,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  mlbb_pkg::csr_addr_type csr_paddr,
   input  mlbb_pkg::csr_data_type csr_pwdata,
   input  mlbb_pkg::csr_data_type csr_prdata,
   input  logic                   csr_pready,
   output int                     mismatches,
   output int                     levels_due
);
   import mlbb_pkg::*;

   cmd_type    slot_cmd [NUM_LEDS];
   millis_type slot_ms  [NUM_LEDS];
   cmd_type    mode     [NUM_LEDS];
   logic       glow     [NUM_LEDS];
   millis_type period   [NUM_LEDS];
   millis_type remain   [NUM_LEDS];
   tick_type   tick_ms;
   levels_type expected_levels [$];
   levels_type want;

   initial begin
      mismatches = 0;
      levels_due = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Walk every LED in index order: take the pending command, then run its countdown.
   function automatic levels_type tick_all_leds();
      levels_type lv = '0;
      cmd_type    c;
      millis_type m;
      for (int i = 0; i < NUM_LEDS; i++) begin
         c = slot_cmd[i];
         m = slot_ms[i];
         slot_cmd[i] = CMD_NONE;
         if (c == mode[i]) begin
            if (c == CMD_BLINK) begin
               period[i] = m;
               if (m < remain[i]) remain[i] = m;
            end else if (c == CMD_BURST) begin
               remain[i] = m;
            end
         end else if (c == CMD_TOGGLE) begin
            glow[i] = !glow[i];
            mode[i] = glow[i] ? CMD_ON : CMD_OFF;
         end else if (c != CMD_NONE) begin
            case (c)
               CMD_OFF:   glow[i] = 1'b0;
               CMD_ON:    glow[i] = 1'b1;
               CMD_BLINK: begin
                  period[i] = m;
                  remain[i] = m;
               end
               CMD_BURST: remain[i] = m;
               default:   ;
            endcase
            mode[i] = c;
         end
         if (mode[i] == CMD_BLINK) begin
            if (remain[i] >= tick_ms) begin
               remain[i] = remain[i] - millis_type'(tick_ms);
            end else begin
               remain[i] = period[i];
               glow[i] = !glow[i];
            end
         end else if (mode[i] == CMD_BURST) begin
            if (remain[i] >= tick_ms) begin
               remain[i] = remain[i] - millis_type'(tick_ms);
               glow[i] = 1'b1;
            end else begin
               glow[i] = 1'b0;
               mode[i] = CMD_OFF;
            end
         end
         if (i < LEVELS_W) lv[i] = glow[i];
      end
      return lv;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEDS; i++) begin
            slot_cmd[i] = CMD_NONE;
            slot_ms[i] = '0;
            mode[i] = CMD_NONE;
            glow[i] = 1'b0;
            period[i] = '0;
            remain[i] = '0;
         end
         tick_ms = TICK_RESET;
         expected_levels.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == CSR_TICK_ADDR) begin
            if (csr_pwrite)
               tick_ms = tick_type'(csr_pwdata);
            else if (csr_prdata !== csr_data_type'(tick_ms))
               report_mismatch($sformatf("tick length read %h, want %h", csr_prdata, tick_ms));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               report_mismatch($sformatf("levels %h with no tick outstanding", rsp_led_levels));
            end else begin
               want = expected_levels.pop_front();
               if (rsp_led_levels !== want)
                  report_mismatch($sformatf("led_levels %h, want %h", rsp_led_levels, want));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_command == CMD_TICK) begin
               expected_levels.push_back(tick_all_leds());
            end else if (req_command <= CMD_BURST && req_led_index < NUM_LEDS) begin
               slot_cmd[req_led_index] = req_command;
               slot_ms[req_led_index] = req_millis;
            end
         end
      end
      levels_due = expected_levels.size();
   end

endmodule

// ===== bench/multi_led_blink_burst_controller_test.sv =====
// Stimulus, clock, reset and verdict for the LED blink and burst controller.
`timescale 1ns / 100ps

module multi_led_blink_burst_controller_test;
   import mlbb_pkg::*;

   localparam int NUM_LEDS       = 9;
   localparam int PHASES         = 5;
   localparam int ITEMS_PER_PHASE = 395;
   // Longest quiet stretch in a correct run is a drain plus a register access;
   // the limit is taken many times over that.
   localparam int WATCHDOG_LIMIT = 1000;
   // Codes past burst: the block must drop them.
   localparam cmd_type CMD_RESERVED_LO = 3'd6;
   localparam cmd_type CMD_RESERVED_HI = 3'd7;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   cmd_type      req_command;
   logic [3:0]   req_led_index;
   millis_type   req_millis;
   logic         rsp_valid;
   logic         rsp_stall;
   levels_type   rsp_led_levels;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   csr_addr_type csr_paddr;
   csr_data_type csr_pwdata;
   csr_data_type csr_prdata;
   logic         csr_pready;

   int mismatches;
   int levels_due;
   // Idle odds in percent, per item for the sender and per cycle for the receiver, changed from phase to phase.
   int send_gap_pct;
   int stall_pct;
   // Tick length currently programmed; shapes the random millis values.
   int tick_cfg;

   multi_led_blink_burst_controller #(
      .NUM_LEDS(NUM_LEDS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_led_index  (req_led_index),
      .req_millis     (req_millis),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_led_levels (rsp_led_levels),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   led_level_checker #(
      .NUM_LEDS(NUM_LEDS)
   ) levels_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_led_index  (req_led_index),
      .req_millis     (req_millis),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_led_levels (rsp_led_levels),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatches     (mismatches),
      .levels_due     (levels_due)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Drive one command or tick; optionally drop valid for a burst first, then hold
   // the payload until the transfer happens.
   task automatic send(input cmd_type c, input logic [3:0] ix, input millis_type ms);
      if ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= c;
      req_led_index <= ix;
      req_millis    <= ms;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid, wait for every level vector to come back, then give the
   // sequencer time to finish any LED walk before touching the register.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (levels_due != 0) @(posedge clock);
      repeat (NUM_LEDS + 4) @(posedge clock);
   endtask

   // Setup cycle, then access cycle held until pready; the checker sees the transfer.
   task automatic csr_access(input logic wr, input csr_addr_type addr,
                             input csr_data_type data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Mostly short values, so countdowns expire within a few ticks; now and then
   // zero or anything up to the full field.
   function automatic millis_type pick_millis();
      case ($urandom_range(0, 7))
         0:       return millis_type'($urandom_range(0, 8191));
         1:       return '0;
         default: return millis_type'($urandom_range(0, tick_cfg * 5 + 3));
      endcase
   endfunction

   // Send one random item; report whether it is one the block acts on.
   task automatic random_item(output bit counted);
      int roll;
      cmd_type c;
      logic [3:0] ix;
      millis_type ms;
      roll = $urandom_range(0, 99);
      counted = 1'b1;
      ms = pick_millis();
      if (roll < 8) begin
         // Noise: reserved codes, or real commands aimed past the last LED.
         counted = 1'b0;
         if ($urandom_range(0, 1)) begin
            c  = cmd_type'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
            ix = 4'($urandom_range(0, 15));
         end else begin
            c  = cmd_type'($urandom_range(CMD_OFF, CMD_BURST));
            ix = 4'($urandom_range(NUM_LEDS, 15));
         end
         ms = millis_type'($urandom_range(0, 8191));
      end else if (roll < 45) begin
         // Tick: index and millis are don't-care, so fill them with anything.
         c  = CMD_TICK;
         ix = 4'($urandom_range(0, 15));
         ms = millis_type'($urandom_range(0, 8191));
      end else begin
         c  = cmd_type'($urandom_range(CMD_OFF, CMD_BURST));
         ix = 4'($urandom_range(0, NUM_LEDS - 1));
      end
      send(c, ix, ms);
   endtask

   // Receiver: stall in random bursts while the phase asks for it.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: end the run when no transfer of any kind happens for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_psel && csr_penable))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int sent;
      bit counted;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_command   = CMD_TICK;
      req_led_index = '0;
      req_millis    = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = CSR_TICK_ADDR;
      csr_pwdata    = '0;
      send_gap_pct  = 10;
      stall_pct     = 10;
      tick_cfg      = TICK_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Tick length must read back at its reset value.
      csr_access(1'b0, CSR_TICK_ADDR, '0);

      // Directed part at the reset tick length of 8 ms.
      send(CMD_TICK, 4'd0, '0);              // every LED idle: all dark
      send(CMD_ON, 4'd0, 13'h1FFF);          // millis with on is kept, never used
      send(CMD_BLINK, 4'd1, 13'd16);
      send(CMD_BURST, 4'd2, 13'd24);
      send(CMD_TOGGLE, 4'd3, '0);            // from idle: lights and goes to on
      send(CMD_OFF, 4'd4, '0);
      send(CMD_ON, 4'd5, '0);                // overwritten before the tick
      send(CMD_OFF, 4'd5, '0);
      send(CMD_BLINK, 4'd8, '0);             // last LED, zero half period
      send(CMD_ON, 4'd9, '0);                // index past the bank: dropped
      send(CMD_BURST, 4'd15, 13'h1FFF);
      send(CMD_RESERVED_LO, 4'd6, 13'd100);  // reserved codes: dropped
      send(CMD_RESERVED_HI, 4'd7, 13'd100);
      send(CMD_TICK, 4'd15, 13'h1FFF);
      send(CMD_BLINK, 4'd1, 13'h1FFF);       // repeated blink: longer period, same countdown
      send(CMD_BURST, 4'd2, 13'h1FFF);       // repeated burst: restart
      send(CMD_TOGGLE, 4'd3, '0);            // toggle acts again
      send(CMD_TOGGLE, 4'd0, '0);
      send(CMD_ON, 4'd6, '0);
      send(CMD_TICK, 4'd0, '0);
      send(CMD_ON, 4'd6, '0);                // repeated on: no change
      send(CMD_BLINK, 4'd1, 13'd4);          // repeated blink: shorter period, same countdown
      send(CMD_BURST, 4'd7, 13'd16);         // burst runs out on the third tick
      repeat (4) send(CMD_TICK, 4'd0, '0);

      // Random phases, each at its own tick length and idle mix; the last one
      // runs with no idling on either side.
      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: begin tick_cfg = 1;   send_gap_pct = 25; stall_pct = 25; end
            1: begin tick_cfg = 255; send_gap_pct = 0;  stall_pct = 40; end
            2: begin tick_cfg = 0;   send_gap_pct = 40; stall_pct = 0;  end
            3: begin tick_cfg = $urandom_range(2, 254); send_gap_pct = 15; stall_pct = 15; end
            default: begin tick_cfg = $urandom_range(1, 255); send_gap_pct = 0; stall_pct = 0; end
         endcase
         csr_access(1'b1, CSR_TICK_ADDR, csr_data_type'(tick_cfg));
         csr_access(1'b0, CSR_TICK_ADDR, '0);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            random_item(counted);
            if (counted) sent++;
         end
      end

      // Drain and decide.
      settle();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== files.f =====
sv/mlbb_pkg.sv
sv/multi_led_blink_burst_controller.sv
bench/led_level_checker.sv
bench/multi_led_blink_burst_controller_test.sv
